/* design/nsr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsr_pkg: shared types and constants for the Heron square root block
// Holds the field widths, the fixed-point constants and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package nsr_pkg;

  // Field widths.
  localparam int unsigned WordW = 32;
  localparam int unsigned IterW = 6;
  localparam int unsigned FracW = 16;
  localparam int unsigned DvdW  = WordW + FracW;

  // Largest number of refinement steps applied to one item.
  localparam int unsigned MAX_ITERATIONS = 63;

  // Bit counter width for the radix-2 divider (counts 0 .. DvdW-1).
  localparam int unsigned BitCntW = $clog2(DvdW);

  // One in Q16.16.
  localparam logic [WordW-1:0] Q_ONE = WordW'(32'h0001_0000);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // Capture the radicand and form the start estimate.
    logic div_init;  // Load the dividend a << 16 into the divider.
    logic div_step;  // One restoring divider step.
    logic update;    // Form the new estimate from the quotient.
    logic out_load;  // Copy the estimate into the output register.
  } nsr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic est_zero;  // Current estimate is zero.
  } nsr_status_t;

endpackage
`default_nettype wire

/* design/nsr_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsr_dp: datapath of the Heron square root block
// Holds the radicand, the estimate, a radix-2 restoring divider for the
// 48-by-32 quotient and the output register.
// ----------------------------------------------------------------------------
module nsr_dp (
  input  wire logic                           clk,
  input  wire nsr_pkg::nsr_cmd_t              cmd,
  input  wire logic [nsr_pkg::WordW-1:0]      radicand,
  output nsr_pkg::nsr_status_t                status,
  output logic [nsr_pkg::WordW-1:0]           root
);

  logic [nsr_pkg::WordW-1:0] a_r, a_nxt;
  logic [nsr_pkg::WordW-1:0] x_r, x_nxt;
  logic [nsr_pkg::WordW-1:0] rem_r, rem_nxt;
  logic [nsr_pkg::DvdW-1:0]  quo_r, quo_nxt;
  logic [nsr_pkg::WordW-1:0] root_r, root_nxt;

  logic [nsr_pkg::WordW:0]   start_sum;
  logic [nsr_pkg::WordW:0]   part_rem;
  logic [nsr_pkg::WordW:0]   trial;
  logic [nsr_pkg::DvdW:0]    new_sum;
  logic [nsr_pkg::DvdW-1:0]  new_half;

  // Start estimate (1 + a) / 2, truncated.
  assign start_sum = {1'b0, radicand} + {1'b0, nsr_pkg::Q_ONE};

  // Trial subtraction of one restoring divider step.
  assign part_rem = {rem_r, quo_r[nsr_pkg::DvdW-1]};
  assign trial    = part_rem - {1'b0, x_r};

  // New estimate (x + q) / 2, saturated to the word width.
  assign new_sum  = {{(nsr_pkg::DvdW - nsr_pkg::WordW + 1){1'b0}}, x_r} + {1'b0, quo_r};
  assign new_half = new_sum[nsr_pkg::DvdW:1];

  // Next-state logic for the datapath registers.
  always_comb begin
    a_nxt    = a_r;
    x_nxt    = x_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    root_nxt = root_r;
    if (cmd.load) begin
      a_nxt = radicand;
      x_nxt = start_sum[nsr_pkg::WordW:1];
    end
    if (cmd.div_init) begin
      rem_nxt = '0;
      quo_nxt = {a_r, {nsr_pkg::FracW{1'b0}}};
    end
    if (cmd.div_step) begin
      if (!trial[nsr_pkg::WordW]) begin
        rem_nxt = trial[nsr_pkg::WordW-1:0];
        quo_nxt = {quo_r[nsr_pkg::DvdW-2:0], 1'b1};
      end else begin
        rem_nxt = part_rem[nsr_pkg::WordW-1:0];
        quo_nxt = {quo_r[nsr_pkg::DvdW-2:0], 1'b0};
      end
    end
    if (cmd.update) begin
      if (|new_half[nsr_pkg::DvdW-1:nsr_pkg::WordW]) begin
        x_nxt = '1;
      end else begin
        x_nxt = new_half[nsr_pkg::WordW-1:0];
      end
    end
    if (cmd.out_load) begin
      root_nxt = x_r;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    x_r    <= x_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    root_r <= root_nxt;
  end

  assign status.est_zero = (x_r == '0);
  assign root            = root_r;

endmodule
`default_nettype wire

/* design/nsr_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsr_ctrl: controller of the Heron square root block
// Sequences the refinement steps and the divider bits, and runs the
// input and output handshakes.
// ----------------------------------------------------------------------------
module nsr_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [nsr_pkg::IterW-1:0]   iterations,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  input  wire nsr_pkg::nsr_status_t        status,
  output nsr_pkg::nsr_cmd_t                cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_UPDATE,
    ST_OUT
  } state_t;

  state_t                       state_r, state_nxt;
  logic [nsr_pkg::IterW-1:0]    iter_r, iter_nxt;
  logic [nsr_pkg::BitCntW-1:0]  bit_r, bit_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [nsr_pkg::IterW-1:0]    iter_lim;

  // Step count limited to the largest supported value.
  always_comb begin
    if (32'(iterations) > nsr_pkg::MAX_ITERATIONS) begin
      iter_lim = nsr_pkg::IterW'(nsr_pkg::MAX_ITERATIONS);
    end else begin
      iter_lim = iterations;
    end
  end

  // Next-state and command logic.
  always_comb begin
    state_nxt     = state_r;
    iter_nxt      = iter_r;
    bit_nxt       = bit_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;

    // The output register empties on a transfer.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          iter_nxt  = iter_lim;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // A zero estimate would make the divisor zero, so the remaining steps are skipped.
        if (iter_r == '0 || status.est_zero) begin
          state_nxt = ST_OUT;
        end else begin
          cmd.div_init = 1'b1;
          bit_nxt      = '0;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        bit_nxt      = bit_r + 1'b1;
        if (bit_r == nsr_pkg::BitCntW'(nsr_pkg::DvdW - 1)) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        iter_nxt   = iter_r - 1'b1;
        state_nxt  = ST_CHECK;
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      iter_r      <= '0;
      bit_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iter_r      <= iter_nxt;
      bit_r       <= bit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

/* design/newton_square_root.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// newton_square_root: Heron square root in unsigned Q16.16
// Takes a radicand and a step count, starts from (1 + a) / 2 and applies
// x = (x + (a << 16) / x) / 2 the requested number of times.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, in_radicand, in_iterations)
//   moves one item per transfer; the result channel (out_valid, out_stall,
//   out_root) moves one root per item, in order.
//   Each refinement step runs a radix-2 restoring divider that retires one
//   quotient bit per cycle over the 48-bit dividend; a step passes through
//   a check state, the divider state for all 48 bits and an update state.
//   An estimate that reaches zero ends the item early. One item is worked
//   on at a time, and in_stall is high from the transfer until the result
//   is written to the output register. The next item is taken while that
//   result still waits.
//   When the receiver stalls, out_root holds and the finished item waits
//   in the controller until the output register empties.
//   Reset (rst_n low at a clock edge) empties the output register and
//   returns the controller to idle; the item in work and any waiting result
//   are dropped.
// ----------------------------------------------------------------------------
module newton_square_root (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [nsr_pkg::WordW-1:0]    in_radicand,
  input  wire logic [nsr_pkg::IterW-1:0]    in_iterations,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [nsr_pkg::WordW-1:0]         out_root
);

  nsr_pkg::nsr_cmd_t    cmd;
  nsr_pkg::nsr_status_t status;

  // Step sequencing and handshakes.
  nsr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .iterations (in_iterations),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .cmd        (cmd)
  );

  // Estimate, divider and output register.
  nsr_dp u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .radicand (in_radicand),
    .status   (status),
    .root     (out_root)
  );

endmodule
`default_nettype wire
